>>> sv/scf_pkg.sv
// shared types and constants of the sharpen and contrast filter
package scf_pkg;

  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 13;
  localparam int ROW_W         = 12;
  localparam int FRAME_W_RESET = 1024;
  localparam int FRAME_H_RESET = 768;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic is_pix;
    logic emit;
    logic interior;
    logic last;
    pix_t pix;
    pix_t up;
    pix_t mid;
  } scf_item_t;

endpackage

>>> sv/scf_ram.sv
// generic single write port ram with registered read
module scf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> sv/scf_front.sv
// front end: input handshake, frame positions, line stores, item classification
module scf_front import scf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,
  input  logic                 s_tuser,
  output logic                 q_push,
  output scf_item_t            q_item,
  input  logic                 q_full
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int W_RST = (MAX_WIDTH < FRAME_W_RESET) ? MAX_WIDTH : FRAME_W_RESET;

  logic [AW-1:0]    w_m1, w_m1_cfg;
  logic [ROW_W-1:0] h_m1, h_m1_cfg;
  logic [AW-1:0]    in_col, out_col;
  logic [ROW_W-1:0] in_row, out_row;
  logic             done;

  logic             acc, rd_en, primed, drain_last, interior, fwd_hit;
  logic [AW-1:0]    rd_addr;
  logic [FW_BITS-1:0] fw;
  logic [FH_BITS-1:0] fh;
  pix_t             in_pix, upper_rdata, middle_rdata, up_eff;

  logic             s1_valid, s1_new, s1_is_pix, s1_emit, s1_interior, s1_last;
  logic             s1_sel_up, s1_fwd;
  logic [AW-1:0]    s1_addr;
  pix_t             s1_pix, s1_fwd_data;

  assign in_pix.red   = s_tdata[7:0];
  assign in_pix.green = s_tdata[15:8];
  assign in_pix.blue  = s_tdata[23:16];

  assign s_tready = !s1_valid || !q_full;
  assign acc      = s_tvalid && s_tready;
  assign rd_en    = acc && (done || !s_tuser);
  assign rd_addr  = done ? out_col : in_col;

  assign primed     = (in_row > ROW_W'(1)) || (in_row == ROW_W'(1) && in_col != '0);
  assign drain_last = (out_col == w_m1) && (out_row == h_m1);
  assign interior   = (out_col != '0) && (out_col < w_m1) &&
                      (out_row != '0) && (out_row < h_m1);
  assign fwd_hit    = s1_new && s1_is_pix && (s1_addr == rd_addr);

  assign fw = cfg_data[FW_BITS-1:0];
  assign fh = cfg_data[FH_BITS-1:0];

  always_comb begin
    if (fw == '0) begin
      w_m1_cfg = '0;
    end else if (32'(fw) > 32'(MAX_WIDTH)) begin
      w_m1_cfg = AW'(MAX_WIDTH - 1);
    end else begin
      w_m1_cfg = AW'(fw - FW_BITS'(1));
    end
    if (fh == '0) begin
      h_m1_cfg = '0;
    end else if (fh > FH_BITS'(HEIGHT_LIMIT)) begin
      h_m1_cfg = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      h_m1_cfg = ROW_W'(fh - FH_BITS'(1));
    end
  end

  // frame positions and effective frame size
  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1    <= AW'(W_RST - 1);
      h_m1    <= ROW_W'(FRAME_H_RESET - 1);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      done    <= 1'b0;
    end else if (cfg_we) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      done    <= 1'b0;
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_m1 <= w_m1_cfg;
        REG_FRAME_HEIGHT: h_m1 <= h_m1_cfg;
        default: ;
      endcase
    end else if (acc) begin
      if (done) begin
        if (drain_last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
          done    <= 1'b0;
        end else if (out_col == w_m1) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + AW'(1);
        end
      end else if (!s_tuser) begin
        if (in_col == w_m1) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= in_col + AW'(1);
        end
        if (in_col == w_m1 && in_row == h_m1) done <= 1'b1;
        if (primed) begin
          if (out_col == w_m1) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + AW'(1);
          end
        end
      end
    end
  end

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_new   <= 1'b0;
    end else begin
      s1_new <= rd_en;
      if (acc) begin
        s1_valid <= rd_en;
      end else if (q_push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_is_pix   <= !done;
      s1_emit     <= primed;
      s1_interior <= interior;
      s1_last     <= drain_last;
      s1_sel_up   <= (out_row != h_m1);
      s1_fwd      <= fwd_hit;
      s1_fwd_data <= middle_rdata;
      s1_addr     <= rd_addr;
      s1_pix      <= in_pix;
    end
  end

  // upper line takes the old middle line in the cycle after the read
  scf_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_new && s1_is_pix),
    .waddr (s1_addr),
    .wdata (middle_rdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (upper_rdata)
  );

  scf_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (acc && !done && !s_tuser),
    .waddr (in_col),
    .wdata (in_pix),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (middle_rdata)
  );

  assign up_eff = s1_fwd ? s1_fwd_data : upper_rdata;
  assign q_push = s1_valid && !q_full;

  always_comb begin
    q_item.is_pix   = s1_is_pix;
    q_item.emit     = s1_is_pix ? s1_emit : 1'b1;
    q_item.interior = s1_is_pix && s1_interior;
    q_item.last     = !s1_is_pix && s1_last;
    q_item.pix      = s1_is_pix ? s1_pix : (s1_sel_up ? up_eff : middle_rdata);
    q_item.up       = up_eff;
    q_item.mid      = middle_rdata;
  end

endmodule

>>> sv/scf_queue.sv
// short item queue between front and back
module scf_queue import scf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  scf_item_t item_in,
  output logic      full,
  output logic      valid,
  input  logic      pop,
  output scf_item_t item_out
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  scf_item_t     entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign item_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= item_in;
  end

endmodule

>>> sv/scf_back.sv
// back end: 3x3 window, sharpen, contrast and output register
module scf_back import scf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  scf_item_t   q_item,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast
);

  pix_t       win [3][3];
  logic [7:0] vr [3][3];
  logic [7:0] vg [3][3];
  logic [7:0] vb [3][3];
  logic       en;
  logic       b1_valid, b1_drain, b1_interior, b1_last;
  pix_t       b1_pix, sel;
  logic       b2_valid, b2_last;
  pix_t       b2_pix;

  function automatic logic [7:0] sharpen(input logic [7:0] v [3][3]);
    logic signed [12:0] sum;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (k == 1 && j == 1) begin
          sum = sum + 13'sd9 * $signed({5'b0, v[k][j]});
        end else begin
          sum = sum - $signed({5'b0, v[k][j]});
        end
      end
    end
    if (sum < 0) begin
      return 8'd0;
    end else if (sum > 13'sd255) begin
      return 8'd255;
    end
    return sum[7:0];
  endfunction

  // clamp((3v - 128) >> 1, 0, 255)
  function automatic logic [7:0] contrast(input logic [7:0] v);
    logic [9:0] t;
    logic [8:0] d;
    t = {2'b0, v} + {1'b0, v, 1'b0};
    d = 9'((t - 10'd128) >> 1);
    if (t < 10'd128) begin
      return 8'd0;
    end else if (d > 9'd255) begin
      return 8'd255;
    end
    return d[7:0];
  endfunction

  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
    end else if (q_pop && q_item.is_pix) begin
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= q_item.up;
      win[2][1] <= q_item.mid;
      win[2][2] <= q_item.pix;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        vr[k][j] = win[k][j].red;
        vg[k][j] = win[k][j].green;
        vb[k][j] = win[k][j].blue;
      end
    end
    if (b1_drain) begin
      sel = b1_pix;
    end else if (b1_interior) begin
      sel.red   = sharpen(vr);
      sel.green = sharpen(vg);
      sel.blue  = sharpen(vb);
    end else begin
      sel = win[1][1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      b1_valid <= q_pop && q_item.emit;
      b2_valid <= b1_valid;
      m_tvalid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_drain    <= !q_item.is_pix;
      b1_interior <= q_item.interior;
      b1_last     <= q_item.last;
      b1_pix      <= q_item.pix;
      b2_pix      <= sel;
      b2_last     <= b1_last;
      m_tdata     <= {contrast(b2_pix.blue), contrast(b2_pix.green), contrast(b2_pix.red)};
      m_tlast     <= b2_last;
    end
  end

endmodule

>>> sv/sharpen_contrast_filter_unit.sv
// top level: 3x3 sharpen with contrast stretch on an rgb pixel stream
// one item per cycle while back-pressure does not hold s_tready low; a result passes the read stage,
// the queue, b1, b2 and the output register; a pixel's result is caused by the item frame_width + 1 later,
// drain items flush the rest; line store read-modify-write is one ram read and one write per pixel item
// on each store, drain items only read; reset clears positions, window and handshakes; sizes return to 1024 x 768
// line stores are not cleared: no clearing pass, the block is ready right after reset
module sharpen_contrast_filter_unit import scf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // in_red, in_green, in_blue
  input  logic                 s_tuser,   // mode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // out_red, out_green, out_blue
  output logic                 m_tlast    // frame_last
);

  logic      q_push, q_full, q_valid, q_pop;
  scf_item_t q_in, q_out;

  scf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_full    (q_full)
  );

  scf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .item_in  (q_in),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .item_out (q_out)
  );

  scf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_out),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
